FILE: rtl/c3g_pkg.sv
// ----------------------------------------------------------------------------
// c3g_pkg: shared types and constants of the 3x3 gray convolution block
// Pixel and coefficient formats, queue sizing, register map and the
// window item that travels from the front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package c3g_pkg;

  localparam int PIX_W          = 8;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 12;
  localparam int COEF_ROW_W     = 3 * COEF_W;
  localparam int PROD_W         = 24;   // 16b signed x 9b signed
  localparam int ROW_SUM_W      = 26;   // three products
  localparam int SUM_W          = 28;   // nine products
  localparam int WIDTH_REG_W    = 13;
  localparam int HEIGHT_W       = 16;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;

  localparam logic [COEF_ROW_W-1:0]  COEF_RESET   = 48'h0200_0200_0200;
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 16'd480;

  typedef enum logic [2:0] {
    REG_COEF_TOP    = 3'd0,
    REG_COEF_MID    = 3'd1,
    REG_COEF_BOTTOM = 3'd2,
    REG_WIDTH       = 3'd3,
    REG_HEIGHT      = 3'd4
  } c3g_reg_e;

  // win[row][col]: row 0 is two lines up, col 0 the oldest column
  typedef struct packed {
    logic [2:0][2:0][PIX_W-1:0] win;
    logic                       last;
  } c3g_item_t;

endpackage

FILE: rtl/c3g_ram.sv
// ----------------------------------------------------------------------------
// c3g_ram: generic single-write, single-read RAM
// One write port and one read port, registered read data (old data on a
// same-address read and write in one cycle).
// ----------------------------------------------------------------------------
module c3g_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/c3g_front.sv
// ----------------------------------------------------------------------------
// c3g_front: position tracking, line stores and 3x3 window
// Accepts one pixel a beat, reads both line stores at its column, then
// shifts the window and hands interior windows to the queue.
// ----------------------------------------------------------------------------
module c3g_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [c3g_pkg::PIX_W-1:0]         pixel_i,
  input  logic                              frame_start_i,
  input  logic [c3g_pkg::WIDTH_REG_W-1:0]   image_width_i,
  input  logic [c3g_pkg::HEIGHT_W-1:0]      image_height_i,
  input  logic [c3g_pkg::QCNT_W-1:0]        q_count_i,
  output logic                              push_o,
  output c3g_pkg::c3g_item_t                item_o
);
  import c3g_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EWW = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;
  localparam logic [EWW-1:0] MAXW = EWW'(MAX_WIDTH);

  logic [EWW-1:0]      w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  logic [CW-1:0]       col_q, col_d;
  logic [HEIGHT_W-1:0] row_q, row_d;

  logic [EWW-1:0]      c0, c1, cn;
  logic [HEIGHT_W:0]   r0, r1, rn;
  logic [CW-1:0]       c;
  logic [HEIGHT_W-1:0] r;
  logic                emit, last, accept;

  logic                s1_valid_q, s1_emit_q, s1_last_q;
  logic [CW-1:0]       s1_col_q;
  logic [PIX_W-1:0]    s1_px_q;
  logic                fwd_q;
  logic [PIX_W-1:0]    fwd_a_q, fwd_b_q;

  logic [PIX_W-1:0]    ram_a_rdata, ram_b_rdata, up1, up2;
  logic [2:0][2:0][PIX_W-1:0] win_q, win_d;

  // Clamp the size registers to the supported range
  always_comb begin
    if (EWW'(image_width_i) < EWW'(3)) begin
      w_eff = EWW'(3);
    end else if (EWW'(image_width_i) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = EWW'(image_width_i);
    end
    h_eff = (image_height_i < HEIGHT_W'(3)) ? HEIGHT_W'(3) : image_height_i;
  end

  // Room for this beat and the one in stage 1 must already exist in the queue
  assign in_ready_o = ((QCNT_W + 1)'(q_count_i) + (QCNT_W + 1)'(s1_valid_q))
                      < (QCNT_W + 1)'(QDEPTH);
  assign accept = in_valid_i && in_ready_o;

  // Position of this pixel and of the next one
  always_comb begin
    c0 = frame_start_i ? '0 : EWW'(col_q);
    r0 = frame_start_i ? '0 : (HEIGHT_W + 1)'(row_q);
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + 1'b1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    if (r1 >= (HEIGHT_W + 1)'(h_eff)) begin
      r1 = '0;
    end
    c = c1[CW-1:0];
    r = r1[HEIGHT_W-1:0];

    emit = (r >= HEIGHT_W'(2)) && (c >= CW'(2));
    last = (r == h_eff - 1'b1) && (EWW'(c) == w_eff - 1'b1);

    cn    = EWW'(c) + 1'b1;
    col_d = cn[CW-1:0];
    row_d = r;
    if (cn >= w_eff) begin
      col_d = '0;
      rn    = (HEIGHT_W + 1)'(r) + 1'b1;
      row_d = (rn >= (HEIGHT_W + 1)'(h_eff)) ? '0 : rn[HEIGHT_W-1:0];
    end else begin
      rn = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        // same column written by stage 1 this cycle: RAM returns stale data
        fwd_q <= s1_valid_q && (s1_col_q == c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q  <= c;
      s1_px_q   <= pixel_i;
      s1_emit_q <= emit;
      s1_last_q <= last;
      fwd_a_q   <= s1_px_q;
      fwd_b_q   <= up1;
    end
  end

  c3g_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (accept),
    .raddr_i (c),
    .rdata_o (ram_a_rdata)
  );

  c3g_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (up1),
    .re_i    (accept),
    .raddr_i (c),
    .rdata_o (ram_b_rdata)
  );

  assign up1 = fwd_q ? fwd_a_q : ram_a_rdata;
  assign up2 = fwd_q ? fwd_b_q : ram_b_rdata;

  always_comb begin
    for (int rr = 0; rr < 3; rr++) begin
      win_d[rr][0] = win_q[rr][1];
      win_d[rr][1] = win_q[rr][2];
    end
    win_d[0][2] = up2;
    win_d[1][2] = up1;
    win_d[2][2] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_valid_q) begin
      win_q <= win_d;
    end
  end

  assign push_o      = s1_valid_q && s1_emit_q;
  assign item_o.win  = win_d;
  assign item_o.last = s1_last_q;

endmodule

FILE: rtl/c3g_queue.sv
// ----------------------------------------------------------------------------
// c3g_queue: short window queue between front end and back end
// Flop-based FIFO; the front end reserves space through the count.
// ----------------------------------------------------------------------------
module c3g_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  c3g_pkg::c3g_item_t        item_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output c3g_pkg::c3g_item_t        item_o,
  output logic [c3g_pkg::QCNT_W-1:0] count_o
);
  import c3g_pkg::*;

  c3g_item_t         slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];
  assign count_o = cnt_q;

endmodule

FILE: rtl/c3g_back.sv
// ----------------------------------------------------------------------------
// c3g_back: nine-tap multiply-accumulate with truncation and saturation
// Products, row sums, then final sum and clamp into the output register.
// ----------------------------------------------------------------------------
module c3g_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  input  c3g_pkg::c3g_item_t                 q_item_i,
  output logic                               q_pop_o,
  input  logic [2:0][c3g_pkg::COEF_ROW_W-1:0] coef_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [c3g_pkg::PIX_W-1:0]          out_pixel_o,
  output logic                               out_last_o
);
  import c3g_pkg::*;

  localparam int SH_W = SUM_W - COEF_FRAC_BITS;

  logic                                   en;
  logic                                   v1_q, v2_q, v3_q;
  logic                                   l1_q, l2_q, l3_q;
  logic [2:0][2:0][PROD_W-1:0]            prod_q, prod_d;
  logic [2:0][ROW_SUM_W-1:0]              rsum_q, rsum_d;
  logic signed [SUM_W-1:0]                sum;
  logic [SH_W-1:0]                        shifted;
  logic [PIX_W-1:0]                       pix_q, pix_d;

  assign en      = !v3_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;

  // Flipped kernel: window (rr, cc) takes coefficient (2-rr, 2-cc)
  always_comb begin
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        prod_d[rr][cc] = PROD_W'(
          $signed(coef_i[2-rr][COEF_W*(2-cc) +: COEF_W]) *
          $signed({1'b0, q_item_i.win[rr][cc]}));
      end
    end
    for (int rr = 0; rr < 3; rr++) begin
      rsum_d[rr] = ROW_SUM_W'($signed(prod_q[rr][0]))
                 + ROW_SUM_W'($signed(prod_q[rr][1]))
                 + ROW_SUM_W'($signed(prod_q[rr][2]));
    end
    sum = SUM_W'($signed(rsum_q[0])) + SUM_W'($signed(rsum_q[1]))
        + SUM_W'($signed(rsum_q[2]));
    shifted = sum[SUM_W-1:COEF_FRAC_BITS];
    if (sum[SUM_W-1] || (sum == '0)) begin
      pix_d = '0;
    end else if (shifted > SH_W'(255)) begin
      pix_d = '1;
    end else begin
      pix_d = shifted[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      l1_q   <= q_item_i.last;
      rsum_q <= rsum_d;
      l2_q   <= l1_q;
      pix_q  <= pix_d;
      l3_q   <= l2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_pixel_o = pix_q;
  assign out_last_o  = l3_q;

endmodule

FILE: rtl/conv3x3_gray_stream.sv
// ----------------------------------------------------------------------------
// conv3x3_gray_stream: streaming 3x3 convolution of an 8-bit gray image
// Raster-order pixels in, one filtered pixel out per interior position.
// ----------------------------------------------------------------------------
// Path: a result beat follows its accepted pixel through 1 window stage,
// 1 queue slot and 3 arithmetic stages; it is held back only while the
// output is stalled.
// Throughput: one pixel per cycle; each line store does one read and one
// write a cycle. Input stalls only when the 4-entry queue is committed.
// Reset (rst_ni low, async): position, window and pipeline valids clear;
// coefficients reset to 1/8 each, size to 640 x 480. The line stores are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module conv3x3_gray_stream #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] gray_pixel
  input  logic                              s_axis_tuser,  // [0] frame_start
  // filtered pixel out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [7:0] filtered_pixel
  output logic                              m_axis_tlast,  // frame_last
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [c3g_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [c3g_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [c3g_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import c3g_pkg::*;

  // Register file. Registers sit at 8-byte spacing; paddr[5:3] is the index.
  logic [COEF_ROW_W-1:0]  coef_top_q, coef_mid_q, coef_bot_q;
  logic [WIDTH_REG_W-1:0] width_q;
  logic [HEIGHT_W-1:0]    height_q;
  logic                   wr_en;
  c3g_reg_e               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = c3g_reg_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_top_q <= COEF_RESET;
      coef_mid_q <= COEF_RESET;
      coef_bot_q <= COEF_RESET;
      width_q    <= WIDTH_RESET;
      height_q   <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COEF_TOP:    coef_top_q <= pwdata[COEF_ROW_W-1:0];
        REG_COEF_MID:    coef_mid_q <= pwdata[COEF_ROW_W-1:0];
        REG_COEF_BOTTOM: coef_bot_q <= pwdata[COEF_ROW_W-1:0];
        REG_WIDTH:       width_q    <= pwdata[WIDTH_REG_W-1:0];
        REG_HEIGHT:      height_q   <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_TOP:    prdata = APB_DATA_W'(coef_top_q);
      REG_COEF_MID:    prdata = APB_DATA_W'(coef_mid_q);
      REG_COEF_BOTTOM: prdata = APB_DATA_W'(coef_bot_q);
      REG_WIDTH:       prdata = APB_DATA_W'(width_q);
      REG_HEIGHT:      prdata = APB_DATA_W'(height_q);
      default:         prdata = '0;
    endcase
  end

  // Front end -> queue -> back end
  c3g_item_t         fe_item, q_item;
  logic              fe_push, q_valid, q_pop;
  logic [QCNT_W-1:0] q_count;
  logic [2:0][COEF_ROW_W-1:0] coef_rows;

  assign coef_rows = {coef_bot_q, coef_mid_q, coef_top_q};

  c3g_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .pixel_i        (s_axis_tdata),
    .frame_start_i  (s_axis_tuser),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .q_count_i      (q_count),
    .push_o         (fe_push),
    .item_o         (fe_item)
  );

  // Queue lets the window builder keep taking beats while output stalls
  c3g_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .item_i  (fe_item),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item),
    .count_o (q_count)
  );

  c3g_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .coef_i      (coef_rows),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: tb/conv3x3_gray_stream_test.sv
// ----------------------------------------------------------------------------
// conv3x3_gray_stream_test: self-checking bench for the 3x3 gray convolution
// Streams pixel frames of many sizes and kernels through the block, predicts
// every filtered pixel with a behavioral copy of the window and line stores,
// and compares the output stream beat by beat. Registers are programmed over
// the APB port between phases, while the block is drained, and read back.
// ----------------------------------------------------------------------------
module conv3x3_gray_stream_test;
  import c3g_pkg::*;

  localparam int MAX_COLS      = 4096;
  localparam int RANDOM_ITEMS  = 700;
  localparam int SETTLE_CYCLES = 8;     // settle margin after the output drains
  localparam int DRAIN_LIMIT   = 2000;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] gray;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } filt_beat_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports (every input starts at a known value)
  // --------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;    // [7:0] gray_pixel
  logic                  s_axis_tuser  = 1'b0;  // [0] frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;          // [7:0] filtered_pixel
  logic                  m_axis_tlast;          // frame_last
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  conv3x3_gray_stream #(
    .MAX_WIDTH(MAX_COLS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // Shadow of the block: registers, line stores, window and raster position
  // --------------------------------------------------------------------------
  logic [COEF_ROW_W-1:0]  coef_rows [3] = '{COEF_RESET, COEF_RESET, COEF_RESET};
  logic [WIDTH_REG_W-1:0] width_reg     = WIDTH_RESET;
  logic [HEIGHT_W-1:0]    height_reg    = HEIGHT_RESET;

  logic [7:0] row_prev  [MAX_COLS] = '{default: '0};  // one line up
  logic [7:0] row_prev2 [MAX_COLS] = '{default: '0};  // two lines up
  logic [7:0] win [3][3]           = '{default: '0};  // [0][*] two lines up
  int         pos_col = 0;                            // next pixel position
  int         pos_row = 0;

  pixel_beat_t pending_pixels [$];     // filled by the sequence, drained by driver
  filt_beat_t  expected_filtered [$];  // predicted output beats, oldest first
  int          pixels_pending = 0;     // queued or on the bus, not yet accepted
  int          err_count      = 0;

  // Size registers as the datapath uses them: clamped, never written back
  function automatic int eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg < 3) return 3;
    return int'(height_reg);
  endfunction

  // Advance the shadow by one accepted pixel and queue its filtered pixel,
  // if the window is centered on an interior position.
  function automatic void convolve_pixel(pixel_beat_t beat);
    int                 w;
    int                 h;
    int                 c;
    int                 r;
    logic [7:0]         up1;
    logic [7:0]         up2;
    longint             acc;
    logic signed [15:0] k;
    filt_beat_t         res;
    w = eff_width();
    h = eff_height();
    if (beat.frame_start) begin
      pos_col = 0;
      pos_row = 0;
    end
    // a size shrunk since the last pixel can leave the position out of range
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    c = pos_col;
    r = pos_row;

    up1          = row_prev[c];
    up2          = row_prev2[c];
    row_prev2[c] = up1;
    row_prev[c]  = beat.gray;
    for (int rr = 0; rr < 3; rr++) begin
      win[rr][0] = win[rr][1];
      win[rr][1] = win[rr][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = beat.gray;

    if (r >= 2 && c >= 2) begin
      // flipped kernel: kernel row 0 / column 0 weight the newest pixel
      acc = 0;
      for (int rr = 0; rr < 3; rr++) begin
        for (int cc = 0; cc < 3; cc++) begin
          k   = coef_rows[2 - rr][COEF_W * (2 - cc) +: COEF_W];
          acc += longint'(k) * longint'(win[rr][cc]);
        end
      end
      // truncate toward zero, then clip to the pixel range
      if (acc <= 0) res.pixel = 8'h00;
      else if ((acc >>> COEF_FRAC_BITS) > 255) res.pixel = 8'hFF;
      else res.pixel = 8'(acc >>> COEF_FRAC_BITS);
      res.last = (r == h - 1) && (c == w - 1);
      expected_filtered.push_back(res);
    end

    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= h) pos_row = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Pixel driver: bursts of random length separated by random gaps. A beat
  // is predicted at the edge where it is accepted.
  // --------------------------------------------------------------------------
  int          burst_left = 0;
  int          gap_left   = 0;
  pixel_beat_t next_beat;

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      convolve_pixel('{frame_start: s_axis_tuser, gray: s_axis_tdata});
      pixels_pending--;
    end
    // bus slot is free unless a beat is still waiting for tready
    if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        next_beat = pending_pixels.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_beat.gray;
        s_axis_tuser  <= next_beat.frame_start;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // long bursts now and then give stretches with no idling at all
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: tready follows a 16-bit pattern that is redrawn each
  // time it runs out; a quarter of the patterns never stall.
  // --------------------------------------------------------------------------
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  stall_phase   = '0;
  filt_beat_t  want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_filtered.size() == 0) begin
        $error("unexpected output beat: filtered_pixel %0d frame_last %0b",
               m_axis_tdata, m_axis_tlast);
        err_count++;
      end else begin
        want = expected_filtered.pop_front();
        if (m_axis_tdata !== want.pixel) begin
          $error("filtered_pixel: expected %0d, got %0d", want.pixel, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, m_axis_tlast);
          err_count++;
        end
      end
    end
    stall_phase   <= stall_phase + 4'd1;
    m_axis_tready <= ready_pattern[stall_phase];
    if (stall_phase == 4'hF) begin
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                   : (16'($urandom) | 16'h0001);
    end
  end

  // --------------------------------------------------------------------------
  // Register access
  // --------------------------------------------------------------------------
  function automatic logic [APB_DATA_W-1:0] reg_mask(c3g_reg_e idx);
    case (idx)
      REG_WIDTH:  return APB_DATA_W'((64'd1 << WIDTH_REG_W) - 1);
      REG_HEIGHT: return APB_DATA_W'((64'd1 << HEIGHT_W) - 1);
      default:    return APB_DATA_W'((64'd1 << COEF_ROW_W) - 1);
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] reg_value(c3g_reg_e idx);
    case (idx)
      REG_WIDTH:  return APB_DATA_W'(width_reg);
      REG_HEIGHT: return APB_DATA_W'(height_reg);
      default:    return APB_DATA_W'(coef_rows[idx - REG_COEF_TOP]);
    endcase
  endfunction

  // setup cycle, then access cycle until pready; data sampled at that edge
  task automatic apb_xfer(input c3g_reg_e idx, input logic wr,
                          input logic [APB_DATA_W-1:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({idx, 3'b000});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic verify_reg(input c3g_reg_e idx);
    logic [APB_DATA_W-1:0] got;
    apb_xfer(idx, 1'b0, '0, got);
    if (got !== reg_value(idx)) begin
      $error("register %s: expected %h, got %h", idx.name(), reg_value(idx), got);
      err_count++;
    end
  endtask

  // write, sometimes with junk above the register's width, then read back
  task automatic program_reg(input c3g_reg_e idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] wdata;
    logic [APB_DATA_W-1:0] unused;
    wdata = value & reg_mask(idx);
    if ($urandom_range(0, 3) == 0) wdata |= {$urandom(), $urandom()} & ~reg_mask(idx);
    apb_xfer(idx, 1'b1, wdata, unused);
    case (idx)
      REG_WIDTH:  width_reg  = wdata[WIDTH_REG_W-1:0];
      REG_HEIGHT: height_reg = wdata[HEIGHT_W-1:0];
      default:    coef_rows[idx - REG_COEF_TOP] = wdata[COEF_ROW_W-1:0];
    endcase
    verify_reg(idx);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_pixel(input logic [7:0] gray, input logic frame_start);
    pending_pixels.push_back('{frame_start: frame_start, gray: gray});
    pixels_pending++;
  endtask

  // Hold off until every pixel is accepted and every result has arrived,
  // then let the pipeline settle (pixels that emit nothing may be in flight).
  task automatic wait_idle();
    int spins;
    spins = 0;
    while (pixels_pending != 0) @(posedge clk_i);
    while (expected_filtered.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spins++;
    end
    if (expected_filtered.size() != 0) begin
      $error("%0d filtered pixels never arrived", expected_filtered.size());
      err_count++;
      expected_filtered.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mix of wild kernels (mostly clipped), smoothing-like ones and extremes
  function automatic logic [COEF_ROW_W-1:0] pick_coef_row();
    logic [COEF_ROW_W-1:0] row;
    int                    mode;
    mode = $urandom_range(0, 4);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0: row[COEF_W*i +: COEF_W] = 16'($urandom);
        1: row[COEF_W*i +: COEF_W] = 16'($urandom_range(0, 'h0600));
        2: row[COEF_W*i +: COEF_W] = 16'($urandom_range(0, 'h1000)) - 16'h0800;
        3: begin
          case ($urandom_range(0, 3))
            0:       row[COEF_W*i +: COEF_W] = 16'h7FFF;
            1:       row[COEF_W*i +: COEF_W] = 16'h8000;
            2:       row[COEF_W*i +: COEF_W] = 16'h0000;
            default: row[COEF_W*i +: COEF_W] = 16'h1000;
          endcase
        end
        default: row[COEF_W*i +: COEF_W] = 16'($urandom_range(0, 'h0300));
      endcase
    end
    return row;
  endfunction

  // small frames keep the run short; below 3 exercises the clamp
  function automatic logic [APB_DATA_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return APB_DATA_W'($urandom_range(0, 2));
      1:       return APB_DATA_W'($urandom_range(13, 40));
      default: return APB_DATA_W'($urandom_range(3, 12));
    endcase
  endfunction

  function automatic logic [APB_DATA_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return APB_DATA_W'($urandom_range(0, 2));
      1:       return APB_DATA_W'($urandom_range(7, 65535));
      default: return APB_DATA_W'($urandom_range(3, 6));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int   random_items;
    int   old_w;
    int   n;
    logic force_start;
    logic fs;
    random_items = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = REG_COEF_TOP; i <= REG_HEIGHT; i++) verify_reg(c3g_reg_e'(i));

    // Directed: sizes below the minimum clamp to a 3x3 frame, one result each.
    // Full-scale positive kernel: white frame saturates high, then a frame of
    // ones (no frame_start, position wraps) checks fractional truncation.
    program_reg(REG_WIDTH, 2);
    program_reg(REG_HEIGHT, 0);
    program_reg(REG_COEF_TOP, 48'h7FFF_7FFF_7FFF);
    program_reg(REG_COEF_MID, 48'h7FFF_7FFF_7FFF);
    program_reg(REG_COEF_BOTTOM, 48'h7FFF_7FFF_7FFF);
    for (int i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);
    for (int i = 0; i < 9; i++) push_pixel(8'h01, 1'b0);
    wait_idle();
    // full-scale negative kernel: negative sum clips to zero
    program_reg(REG_COEF_TOP, 48'h8000_8000_8000);
    program_reg(REG_COEF_MID, 48'h8000_8000_8000);
    program_reg(REG_COEF_BOTTOM, 48'h8000_8000_8000);
    for (int i = 0; i < 9; i++) push_pixel(8'hFF, i == 0);
    wait_idle();

    // Oversized width clamps to the store depth, tallest frame: part of the
    // first line only, so no results yet.
    program_reg(REG_WIDTH, APB_DATA_W'((64'd1 << WIDTH_REG_W) - 1));
    program_reg(REG_HEIGHT, 65535);
    program_reg(REG_COEF_TOP, pick_coef_row());
    program_reg(REG_COEF_MID, pick_coef_row());
    program_reg(REG_COEF_BOTTOM, pick_coef_row());
    for (int i = 0; i < 300; i++) push_pixel(pick_pixel(), i == 0);
    wait_idle();
    // Shrink both sizes mid-line: the column is past the new width, so the
    // position moves to the start of the next row. Two frames' worth of
    // pixels follow without frame_start.
    program_reg(REG_WIDTH, 64);
    program_reg(REG_HEIGHT, 3);
    for (int i = 0; i < 2 * 64 * 3; i++) push_pixel(pick_pixel(), 1'b0);

    // Random phases. Each one drains the block (sender held off until every
    // result is back), rewrites some registers and streams whole or partial
    // frames with occasional stray frame_start markers.
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      old_w = eff_width();
      if ($urandom_range(0, 1) == 1) program_reg(REG_WIDTH, pick_width());
      if ($urandom_range(0, 1) == 1) program_reg(REG_HEIGHT, pick_height());
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(0, 2) == 0) begin
          program_reg(c3g_reg_e'(REG_COEF_TOP + r), pick_coef_row());
        end
      end
      // a wider line mid-frame would read line store columns that this frame
      // never wrote, so restart the frame whenever the width grows
      force_start = (eff_width() > old_w) && (pos_col != 0 || pos_row != 0);
      n = $urandom_range(1, 3) * eff_width() * eff_height();
      if (n > 240) n = $urandom_range(60, 240);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) begin
        fs = (i == 0) ? (force_start || ($urandom_range(0, 1) == 1))
                      : ($urandom_range(0, 63) == 0);
        push_pixel(pick_pixel(), fs);
      end
      random_items += n;
    end

    wait_idle();
    if (err_count == 0) begin
      $display("conv3x3_gray_stream_test: clean");
    end else begin
      $display("conv3x3_gray_stream_test: errors");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run (all gaps and stalls maximal)
  initial begin
    #20_000_000;
    $display("conv3x3_gray_stream_test: errors");
    $finish;
  end

endmodule

FILE: files.f
rtl/c3g_pkg.sv
rtl/c3g_ram.sv
rtl/c3g_front.sv
rtl/c3g_queue.sv
rtl/c3g_back.sv
rtl/conv3x3_gray_stream.sv
tb/conv3x3_gray_stream_test.sv
